@@ rtl/core/spm_pkg.sv @@
// Shared types and constants for the stream presence hysteresis monitor.
package spm_pkg;

  // Presence states of the hysteresis machine.
  typedef enum logic [1:0] {
    PRES_OK        = 2'd0,
    PRES_LOST      = 2'd1,
    PRES_RESTORING = 2'd2,
    PRES_NONE      = 2'd3
  } presence_t;

  // Stream kind codes; code 3 is unused and handled as other.
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_AUDIO = 2'd1;
  localparam logic [1:0] KIND_PMT   = 2'd2;

  // PIDs below this limit, and the null PID, are reserved.
  localparam logic [12:0] PID_RESERVED_LIMIT = 13'h0020;
  localparam logic [12:0] PID_NULL           = 13'h1fff;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH = 24;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_MIN_TRAFFIC   = 2'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_OFF_TIMEOUT   = 2'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_ON_TIMEOUT    = 2'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_AUDIO_CC_MASK = 2'd3;

  // Stream port widths; the tdata widths are padded to whole bytes.
  localparam int unsigned IN_TDATA_WIDTH  = 56;
  localparam int unsigned IN_TUSER_WIDTH  = 2;
  localparam int unsigned OUT_TDATA_WIDTH = 24;

  // Current configuration.
  typedef struct packed {
    logic [23:0] min_traffic_bytes;
    logic [15:0] off_timeout;
    logic [15:0] on_timeout;
    logic        audio_cc_mask;
  } cfg_t;

  // One per-second stream report.
  typedef struct packed {
    logic [12:0] stream_pid;
    logic [1:0]  stream_kind;
    logic [23:0] byte_count;
    logic [15:0] cc_error_count;
  } item_t;

  // One judgment result.
  typedef struct packed {
    presence_t   presence_state;
    logic        stream_good;
    logic        status_changed;
    logic        low_traffic;
    logic        cc_error_second;
    logic [15:0] cc_errors_counted;
  } result_t;

endpackage

@@ rtl/core/spm_cfg_regs.sv @@
// Configuration register file of the stream presence hysteresis monitor.
module spm_cfg_regs
  import spm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  output cfg_t                      cfg
);

  // Register writes; each register keeps only its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_traffic_bytes <= 24'd0;
      cfg.off_timeout       <= 16'd1;
      cfg.on_timeout        <= 16'd1;
      cfg.audio_cc_mask     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_TRAFFIC:   cfg.min_traffic_bytes <= cfg_wdata[23:0];
        REG_OFF_TIMEOUT:   cfg.off_timeout       <= cfg_wdata[15:0];
        REG_ON_TIMEOUT:    cfg.on_timeout        <= cfg_wdata[15:0];
        REG_AUDIO_CC_MASK: cfg.audio_cc_mask     <= cfg_wdata[0];
      endcase
    end
  end

endmodule

@@ rtl/core/spm_presence_fsm.sv @@
// Presence hysteresis state machine with hold counter and result logic.
module spm_presence_fsm
  import spm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step_en,
  input  cfg_t    cfg,
  input  item_t   item,
  output result_t result
);

  // Largest value the hold counter can hold.
  localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [COUNT_WIDTH-1:0] CountOne = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  presence_t              state;
  presence_t              state_next;
  presence_t              state_eff;
  logic [COUNT_WIDTH-1:0] hold_counter;
  logic [COUNT_WIDTH-1:0] hold_next;
  logic                   good_flag;
  logic                   good_next;
  logic                   good_eff;
  logic                   reserved;
  logic                   forced;
  logic                   low;
  logic                   traffic_good;
  logic                   fsm_changed;
  logic                   counted;
  logic [31:0]            off_ext;
  logic [31:0]            on_ext;
  logic [COUNT_WIDTH-1:0] off_load;
  logic [COUNT_WIDTH-1:0] on_load;

  // Timeout load values: zero counts as one, then saturate to the counter range.
  always_comb begin
    off_ext  = {16'd0, (cfg.off_timeout == 16'd0) ? 16'd1 : cfg.off_timeout};
    on_ext   = {16'd0, (cfg.on_timeout == 16'd0) ? 16'd1 : cfg.on_timeout};
    off_load = (off_ext > CountMax[31:0]) ? CountMax[COUNT_WIDTH-1:0]
                                          : off_ext[COUNT_WIDTH-1:0];
    on_load  = (on_ext > CountMax[31:0]) ? CountMax[COUNT_WIDTH-1:0]
                                         : on_ext[COUNT_WIDTH-1:0];
  end

  // Classification: reserved PIDs and PMT streams are forced to ok first.
  always_comb begin
    reserved     = (item.stream_pid < PID_RESERVED_LIMIT) || (item.stream_pid == PID_NULL);
    forced       = reserved || (item.stream_kind == KIND_PMT);
    state_eff    = forced ? PRES_OK : state;
    good_eff     = forced ? 1'b1 : good_flag;
    low          = !reserved && (item.byte_count < cfg.min_traffic_bytes);
    traffic_good = !low;
  end

  // Next state of the hysteresis machine.
  always_comb begin
    state_next  = state_eff;
    hold_next   = hold_counter;
    good_next   = good_eff;
    fsm_changed = 1'b0;
    unique case (state_eff)
      PRES_OK: begin
        if (!traffic_good) begin
          state_next  = PRES_LOST;
          hold_next   = off_load;
          fsm_changed = 1'b1;
        end
      end
      PRES_LOST: begin
        if (traffic_good) begin
          state_next  = PRES_RESTORING;
          hold_next   = on_load;
          fsm_changed = 1'b1;
        end else if (hold_counter != '0) begin
          hold_next = hold_counter - CountOne;
        end else begin
          state_next  = PRES_NONE;
          good_next   = 1'b0;
          fsm_changed = 1'b1;
        end
      end
      PRES_RESTORING: begin
        if (!traffic_good) begin
          state_next  = PRES_LOST;
          hold_next   = off_load;
          fsm_changed = 1'b1;
        end else if (hold_counter != '0) begin
          hold_next = hold_counter - CountOne;
        end else begin
          state_next  = PRES_OK;
          good_next   = 1'b1;
          fsm_changed = 1'b1;
        end
      end
      PRES_NONE: begin
        if (traffic_good) begin
          state_next  = PRES_RESTORING;
          hold_next   = on_load;
          fsm_changed = 1'b1;
        end
      end
    endcase
  end

  // Continuity errors and the result fields.
  always_comb begin
    counted = !((item.stream_kind == KIND_AUDIO) && cfg.audio_cc_mask) &&
              (item.cc_error_count != 16'd0);
    result.presence_state    = state_next;
    result.stream_good       = good_next;
    result.status_changed    = fsm_changed || counted;
    result.low_traffic       = low;
    result.cc_error_second   = counted;
    result.cc_errors_counted = counted ? item.cc_error_count : 16'd0;
  end

  // State registers advance once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= PRES_OK;
      hold_counter <= '0;
      good_flag    <= 1'b1;
    end else if (step_en) begin
      state        <= state_next;
      hold_counter <= hold_next;
      good_flag    <= good_next;
    end
  end

  // The ok state always carries a good stream.
  assert property (@(posedge clk) disable iff (rst) (state == PRES_OK) |-> good_flag)
    else $error("ok state without good flag");

  // The none state always carries a bad stream.
  assert property (@(posedge clk) disable iff (rst) (state == PRES_NONE) |-> !good_flag)
    else $error("none state with good flag");

  // Entering lost or restoring loads a nonzero hold count.
  assert property (@(posedge clk) disable iff (rst)
      (step_en && (state_next != state_eff) &&
       ((state_next == PRES_LOST) || (state_next == PRES_RESTORING)))
      |=> (hold_counter != '0))
    else $error("hold counter not loaded on entry");

  // State holds when no transaction is processed.
  assert property (@(posedge clk) disable iff (rst)
      !step_en |=> ($stable(state) && $stable(hold_counter) && $stable(good_flag)))
    else $error("state moved without a transaction");

endmodule

@@ rtl/core/stream_presence_hysteresis_monitor.sv @@
// Top level: stream ports, input register, presence machine and result register.
// Flow: an accepted transaction is held in the input register, judged by the presence
// step and written into the result register once the output can advance.
// Throughput: one report per cycle while the output does not stall; the input register,
// the presence step and the result register form a two-stage pipeline.
// Reset (rst, synchronous): both pipeline stages empty, state ok, hold counter zero,
// good flag set, min_traffic_bytes 0, timeouts 1, audio errors not ignored.
module stream_presence_hysteresis_monitor
  import spm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic [CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  // Input stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: stream_pid[12:0], byte_count[36:13], cc_error_count[52:37], zero pad.
  input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  // tuser: stream_kind[1:0].
  input  logic [IN_TUSER_WIDTH-1:0]  s_axis_tuser,
  // Output stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata: presence_state[1:0], stream_good[2], status_changed[3], low_traffic[4],
  // cc_error_second[5], cc_errors_counted[21:6], zero pad.
  output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t result;
  result_t out_result;
  logic    out_valid;
  logic    advance;
  logic    step_en;

  // Pipeline flow control.
  assign advance       = !out_valid || m_axis_tready;
  assign step_en       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  spm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.stream_pid     <= s_axis_tdata[12:0];
      in_item.byte_count     <= s_axis_tdata[36:13];
      in_item.cc_error_count <= s_axis_tdata[52:37];
      in_item.stream_kind    <= s_axis_tuser[1:0];
    end
  end

  spm_presence_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_presence_fsm (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .cfg     (cfg),
    .item    (in_item),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00,
                          out_result.cc_errors_counted,
                          out_result.cc_error_second,
                          out_result.low_traffic,
                          out_result.status_changed,
                          out_result.stream_good,
                          out_result.presence_state};

endmodule
